>>> hdl/fix_tvp_pkg.sv
// Shared types and constants for the FIX tag=value parser.
// Used by every module of the block; has no dependencies of its own.
package fix_tvp_pkg;

    // Stream widths: one message byte in, one packed result word out.
    localparam int BYTE_W      = 8;
    localparam int TYPE_W      = 16;
    localparam int SYMBOL_W    = 64;
    localparam int PRICE_W     = 64;
    localparam int QTY_W       = 64;
    localparam int SIDE_W      = 2;
    localparam int RESULT_W    = TYPE_W + SYMBOL_W + PRICE_W + QTY_W + SIDE_W + 1;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int DEC_W       = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIELD_SEP  = 1'b0,
        CFG_PRICE_DEC  = 1'b1
    } cfg_index_t;

    localparam logic [BYTE_W-1:0] SEP_RESET    = 8'd124;
    localparam logic [DEC_W-1:0]  DEC_RESET    = 4'd4;
    localparam logic [DEC_W-1:0]  MAX_DECIMALS = 4'd8;

    // Default sizes of the text fields kept from a message.
    localparam int DEF_SYMBOL_BYTES = 8;
    localparam int DEF_TYPE_BYTES   = 2;

    // Side codes.
    localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_SELL = 2'd2;

    // Magnitude limit of a signed 64-bit price (two to the 63rd).
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

    // Price finishing request raised when a price field closes.
    typedef struct packed {
        logic        valid;
        logic        bad;
        logic        over;
        logic        neg;
        logic [63:0] mag;
        logic [3:0]  k;
    } price_ev_t;

    // Price after the scaling multiply, before sign and saturation.
    typedef struct packed {
        logic        valid;
        logic        bad;
        logic        over;
        logic        neg;
        logic [63:0] prod;
    } price_sum_t;

    // Everything of a result except the price, known when the message ends.
    typedef struct packed {
        logic                valid;
        logic [TYPE_W-1:0]   msg_type;
        logic [SYMBOL_W-1:0] symbol;
        logic [QTY_W-1:0]    qty;
        logic [SIDE_W-1:0]   side;
        logic                err;
    } result_t;

endpackage

>>> hdl/fix_tvp_parse.sv
// Byte parser of the FIX tag=value parser: field and tag decoding, number
// accumulation and held message fields, ending in the first pipeline register.
// Depends on fix_tvp_pkg.
module fix_tvp_parse #(
    parameter int TYPE_BYTES   = fix_tvp_pkg::DEF_TYPE_BYTES,
    parameter int SYMBOL_BYTES = fix_tvp_pkg::DEF_SYMBOL_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [7:0]            field_sep,
    input  logic [3:0]            price_dec,
    input  logic                  adv,
    output fix_tvp_pkg::price_ev_t ev_out,
    output fix_tvp_pkg::result_t   res_out
);
    import fix_tvp_pkg::*;

    localparam int TYPE_BITS = 8 * TYPE_BYTES;
    localparam int SYM_BITS  = 8 * SYMBOL_BYTES;

    // After one tag byte, TAG_35, TAG_55 and TAG_44 stand for the prefixes
    // '3', '5' and '4'; after two bytes they name the complete tag.
    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_35   = 3'd1,
        TAG_55   = 3'd2,
        TAG_44   = 3'd3,
        TAG_38   = 3'd4,
        TAG_54   = 3'd5
    } tag_t;

    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_4     = 8'h34;
    localparam logic [7:0] CHAR_5     = 8'h35;
    localparam logic [7:0] CHAR_8     = 8'h38;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // Largest accumulator that still takes one more digit without overflow.
    localparam logic [63:0] PRICE_DIGIT_MAX = MAG_LIMIT / 64'd10;
    localparam logic [63:0] QTY_DIGIT_MAX   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd10;
    localparam logic [3:0]  PRICE_TOP_DIGIT = 4'd8;
    localparam logic [3:0]  QTY_TOP_DIGIT   = 4'd5;
    localparam logic [3:0]  COUNT_MAX       = 4'd15;

    // Field state.
    logic                 in_value_reg, in_value_next;
    tag_t                 tag_reg, tag_next;
    logic [1:0]           tag_len_reg, tag_len_next;
    logic [63:0]          acc_reg, acc_next;
    logic [3:0]           frac_reg, frac_next;
    logic                 neg_reg, neg_next;
    logic                 dot_reg, dot_next;
    logic                 digit_reg, digit_next;
    logic                 bad_reg, bad_next;
    logic [3:0]           vcount_reg, vcount_next;
    logic                 over_reg, over_next;

    // Message state.
    logic [TYPE_BITS-1:0] type_reg, type_next;
    logic [SYM_BITS-1:0]  sym_reg, sym_next;
    logic [63:0]          qty_reg, qty_next;
    logic [1:0]           side_reg, side_next;
    logic                 err_reg, err_next;

    // First pipeline stage.
    price_ev_t            ev_reg, ev_next;
    result_t              res_reg, res_next;

    logic [3:0]           dec_eff;
    logic                 is_sep;
    logic                 is_digit;
    logic [3:0]           digit_val;
    logic [63:0]          push_thr;
    logic [63:0]          acc_push;
    logic                 push_over;

    assign dec_eff   = (price_dec > MAX_DECIMALS) ? MAX_DECIMALS : price_dec;
    assign is_sep    = (in_byte == field_sep);
    assign is_digit  = (in_byte >= CHAR_0) && (in_byte <= CHAR_9);
    assign digit_val = in_byte[3:0];

    // One decimal digit step: limit check and acc * 10 + d.
    always_comb begin
        if (tag_reg == TAG_44) begin
            push_thr = (digit_val > PRICE_TOP_DIGIT) ? PRICE_DIGIT_MAX - 64'd1
                                                     : PRICE_DIGIT_MAX;
        end else begin
            push_thr = (digit_val > QTY_TOP_DIGIT) ? QTY_DIGIT_MAX - 64'd1
                                                   : QTY_DIGIT_MAX;
        end
    end

    assign push_over = (acc_reg > push_thr);
    assign acc_push  = (acc_reg << 3) + (acc_reg << 1) + {60'd0, digit_val};

    // Byte handling, field close and message end.
    always_comb begin
        in_value_next = in_value_reg;
        tag_next      = tag_reg;
        tag_len_next  = tag_len_reg;
        acc_next      = acc_reg;
        frac_next     = frac_reg;
        neg_next      = neg_reg;
        dot_next      = dot_reg;
        digit_next    = digit_reg;
        bad_next      = bad_reg;
        vcount_next   = vcount_reg;
        over_next     = over_reg;
        type_next     = type_reg;
        sym_next      = sym_reg;
        qty_next      = qty_reg;
        side_next     = side_reg;
        err_next      = err_reg;
        ev_next       = '0;
        res_next      = '0;

        if (in_accept) begin
            if (!is_sep) begin
                if (in_value_reg) begin
                    // A byte of the value part.
                    unique case (tag_reg)
                        TAG_35: begin
                            for (int i = 0; i < TYPE_BYTES; i++) begin
                                if (vcount_reg == 4'(TYPE_BYTES - 1 - i)) begin
                                    type_next[8*i +: 8] = in_byte;
                                end
                            end
                        end
                        TAG_55: begin
                            for (int i = 0; i < SYMBOL_BYTES; i++) begin
                                if (vcount_reg == 4'(SYMBOL_BYTES - 1 - i)) begin
                                    sym_next[8*i +: 8] = in_byte;
                                end
                            end
                        end
                        TAG_54: begin
                            if (vcount_reg == 4'd0 && in_byte == CHAR_1) begin
                                digit_next = 1'b1;
                            end
                        end
                        TAG_44: begin
                            if (is_digit) begin
                                digit_next = 1'b1;
                                if (!dot_reg || frac_reg < dec_eff) begin
                                    if (!over_reg) begin
                                        if (push_over) begin
                                            over_next = 1'b1;
                                        end else begin
                                            acc_next = acc_push;
                                        end
                                    end
                                    if (dot_reg) begin
                                        frac_next = frac_reg + 4'd1;
                                    end
                                end
                            end else if (in_byte == CHAR_DOT && !dot_reg) begin
                                dot_next = 1'b1;
                            end else if ((in_byte == CHAR_MINUS || in_byte == CHAR_PLUS)
                                         && vcount_reg == 4'd0) begin
                                neg_next = (in_byte == CHAR_MINUS);
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        TAG_38: begin
                            if (is_digit) begin
                                digit_next = 1'b1;
                                if (!over_reg) begin
                                    if (push_over) begin
                                        over_next = 1'b1;
                                    end else begin
                                        acc_next = acc_push;
                                    end
                                end
                            end else if (!(in_byte == CHAR_PLUS && vcount_reg == 4'd0)) begin
                                bad_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (vcount_reg < COUNT_MAX) begin
                        vcount_next = vcount_reg + 4'd1;
                    end
                end else if (in_byte == CHAR_EQ) begin
                    // First '=' of the field: the value part starts.
                    if (tag_len_reg != 2'd2) begin
                        tag_next = TAG_NONE;
                    end
                    in_value_next = 1'b1;
                    if (tag_next == TAG_35) begin
                        type_next = '0;
                    end else if (tag_next == TAG_55) begin
                        sym_next = '0;
                    end
                end else begin
                    // A byte of the tag.
                    if (tag_len_reg >= 2'd2) begin
                        tag_len_next = 2'd3;
                        tag_next     = TAG_NONE;
                    end else if (tag_len_reg == 2'd0) begin
                        tag_len_next = 2'd1;
                        if (in_byte == CHAR_3) begin
                            tag_next = TAG_35;
                        end else if (in_byte == CHAR_5) begin
                            tag_next = TAG_55;
                        end else if (in_byte == CHAR_4) begin
                            tag_next = TAG_44;
                        end else begin
                            tag_next = TAG_NONE;
                        end
                    end else begin
                        tag_len_next = 2'd2;
                        tag_next     = TAG_NONE;
                        if (tag_reg == TAG_35 && in_byte == CHAR_5) begin
                            tag_next = TAG_35;
                        end else if (tag_reg == TAG_35 && in_byte == CHAR_8) begin
                            tag_next = TAG_38;
                        end else if (tag_reg == TAG_55 && in_byte == CHAR_5) begin
                            tag_next = TAG_55;
                        end else if (tag_reg == TAG_55 && in_byte == CHAR_4) begin
                            tag_next = TAG_54;
                        end else if (tag_reg == TAG_44 && in_byte == CHAR_4) begin
                            tag_next = TAG_44;
                        end
                    end
                end
            end

            // Close the open field on a separator or on the final byte.
            if (is_sep || in_last) begin
                if (in_value_next) begin
                    unique case (tag_next)
                        TAG_44: begin
                            ev_next.valid = 1'b1;
                            ev_next.bad   = bad_next || !digit_next;
                            ev_next.over  = over_next;
                            ev_next.neg   = neg_next;
                            ev_next.mag   = acc_next;
                            ev_next.k     = (dec_eff > frac_next) ? dec_eff - frac_next
                                                                  : 4'd0;
                            if (bad_next || !digit_next) begin
                                err_next = 1'b1;
                            end
                        end
                        TAG_38: begin
                            if (bad_next || !digit_next) begin
                                qty_next = '0;
                                err_next = 1'b1;
                            end else if (over_next) begin
                                qty_next = '1;
                                err_next = 1'b1;
                            end else begin
                                qty_next = acc_next;
                            end
                        end
                        TAG_54: begin
                            side_next = (vcount_next == 4'd1 && digit_next) ? SIDE_BUY
                                                                            : SIDE_SELL;
                        end
                        default: begin
                        end
                    endcase
                end
                in_value_next = 1'b0;
                tag_next      = TAG_NONE;
                tag_len_next  = 2'd0;
                acc_next      = '0;
                frac_next     = 4'd0;
                neg_next      = 1'b0;
                dot_next      = 1'b0;
                digit_next    = 1'b0;
                bad_next      = 1'b0;
                vcount_next   = 4'd0;
                over_next     = 1'b0;
            end

            // Message end: hand over the held fields and start afresh.
            if (in_last) begin
                res_next.valid    = 1'b1;
                res_next.msg_type = TYPE_W'(type_next);
                res_next.symbol   = SYMBOL_W'(sym_next);
                res_next.qty      = qty_next;
                res_next.side     = side_next;
                res_next.err      = err_next;
                type_next         = '0;
                sym_next          = '0;
                qty_next          = '0;
                side_next         = SIDE_NONE;
                err_next          = 1'b0;
            end
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg <= 1'b0;
            tag_reg      <= TAG_NONE;
            tag_len_reg  <= 2'd0;
            acc_reg      <= '0;
            frac_reg     <= 4'd0;
            neg_reg      <= 1'b0;
            dot_reg      <= 1'b0;
            digit_reg    <= 1'b0;
            bad_reg      <= 1'b0;
            vcount_reg   <= 4'd0;
            over_reg     <= 1'b0;
            type_reg     <= '0;
            sym_reg      <= '0;
            qty_reg      <= '0;
            side_reg     <= SIDE_NONE;
            err_reg      <= 1'b0;
        end else begin
            in_value_reg <= in_value_next;
            tag_reg      <= tag_next;
            tag_len_reg  <= tag_len_next;
            acc_reg      <= acc_next;
            frac_reg     <= frac_next;
            neg_reg      <= neg_next;
            dot_reg      <= dot_next;
            digit_reg    <= digit_next;
            bad_reg      <= bad_next;
            vcount_reg   <= vcount_next;
            over_reg     <= over_next;
            type_reg     <= type_next;
            sym_reg      <= sym_next;
            qty_reg      <= qty_next;
            side_reg     <= side_next;
            err_reg      <= err_next;
        end
    end

    // First pipeline register, frozen while the output side is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg  <= '0;
            res_reg <= '0;
        end else if (adv) begin
            ev_reg  <= ev_next;
            res_reg <= res_next;
        end
    end

    assign ev_out  = ev_reg;
    assign res_out = res_reg;

endmodule

>>> hdl/fix_tvp_price.sv
// Price scaling pipeline of the FIX tag=value parser: range check against
// the scale and a 64 by 27 bit multiply in two partial products.
// Depends on fix_tvp_pkg.
module fix_tvp_price (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  fix_tvp_pkg::price_ev_t  ev_in,
    input  fix_tvp_pkg::result_t    res_in,
    output fix_tvp_pkg::price_sum_t sum_out,
    output fix_tvp_pkg::result_t    res_out
);
    import fix_tvp_pkg::*;

    localparam int POW_W  = 27;
    localparam int PART_W = 32 + POW_W;

    // Powers of ten for padding the fraction.
    localparam logic [POW_W-1:0] POW_TEN [9] = '{
        27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
        27'd1000000, 27'd10000000, 27'd100000000
    };

    // Largest magnitude that may be scaled by each power of ten.
    localparam logic [63:0] LIMIT_DIV [9] = '{
        MAG_LIMIT,
        MAG_LIMIT / 64'd10,
        MAG_LIMIT / 64'd100,
        MAG_LIMIT / 64'd1000,
        MAG_LIMIT / 64'd10000,
        MAG_LIMIT / 64'd100000,
        MAG_LIMIT / 64'd1000000,
        MAG_LIMIT / 64'd10000000,
        MAG_LIMIT / 64'd100000000
    };

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic              over;
        logic              neg;
        logic [PART_W-1:0] lo;
        logic [31:0]       hi;
    } price_mid_t;

    price_mid_t        mid_reg, mid_next;
    price_sum_t        sum_reg, sum_next;
    result_t           res2_reg, res3_reg;
    logic [POW_W-1:0]  scale;
    logic [PART_W-1:0] hi_full;

    // Stage two: range check and the two partial products.
    assign scale   = POW_TEN[ev_in.k];
    assign hi_full = PART_W'(ev_in.mag[63:32]) * PART_W'(scale);

    always_comb begin
        mid_next.valid = ev_in.valid;
        mid_next.bad   = ev_in.bad;
        mid_next.over  = ev_in.over || (ev_in.mag > LIMIT_DIV[ev_in.k]);
        mid_next.neg   = ev_in.neg;
        mid_next.lo    = PART_W'(ev_in.mag[31:0]) * PART_W'(scale);
        mid_next.hi    = hi_full[31:0];
    end

    // Stage three: partial products summed modulo two to the 64th.
    always_comb begin
        sum_next.valid = mid_reg.valid;
        sum_next.bad   = mid_reg.bad;
        sum_next.over  = mid_reg.over;
        sum_next.neg   = mid_reg.neg;
        sum_next.prod  = 64'(mid_reg.lo) + {mid_reg.hi, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg  <= '0;
            sum_reg  <= '0;
            res2_reg <= '0;
            res3_reg <= '0;
        end else if (adv) begin
            mid_reg  <= mid_next;
            sum_reg  <= sum_next;
            res2_reg <= res_in;
            res3_reg <= res2_reg;
        end
    end

    assign sum_out = sum_reg;
    assign res_out = res3_reg;

endmodule

>>> hdl/fix_tvp_out.sv
// Output stage of the FIX tag=value parser: held price with sign and
// saturation, result register and skid register on the output stream.
// Depends on fix_tvp_pkg.
module fix_tvp_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fix_tvp_pkg::price_sum_t           sum_in,
    input  fix_tvp_pkg::result_t              res_in,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [fix_tvp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                              adv
);
    import fix_tvp_pkg::*;

    localparam logic [63:0] PRICE_MAX = MAG_LIMIT - 64'd1;

    logic [63:0]          held_price_reg, held_price_next;
    logic                 perr_reg, perr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;
    logic [63:0]          price_upd;
    logic                 perr_upd;
    logic [M_TDATA_W-1:0] out_word;

    // The pipeline moves whenever the skid register is free.
    assign adv = !skid_valid_reg;

    // Apply a finished price to the held price.
    always_comb begin
        price_upd = held_price_reg;
        perr_upd  = perr_reg;
        if (sum_in.valid) begin
            if (sum_in.bad) begin
                price_upd = '0;
            end else if (sum_in.over) begin
                price_upd = sum_in.neg ? MAG_LIMIT : PRICE_MAX;
                perr_upd  = 1'b1;
            end else if (!sum_in.neg && sum_in.prod[63]) begin
                price_upd = PRICE_MAX;
                perr_upd  = 1'b1;
            end else begin
                price_upd = sum_in.neg ? (64'd0 - sum_in.prod) : sum_in.prod;
            end
        end
    end

    assign out_word = M_TDATA_W'({res_in.err || perr_upd, res_in.side, res_in.qty,
                                  price_upd, res_in.symbol, res_in.msg_type});

    // Held price, result register and skid register.
    always_comb begin
        held_price_next = held_price_reg;
        perr_next       = perr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (adv) begin
            held_price_next = res_in.valid ? 64'd0 : price_upd;
            perr_next       = res_in.valid ? 1'b0 : perr_upd;
            if (!m_valid_reg || m_tready) begin
                m_valid_next = res_in.valid;
                m_data_next  = out_word;
            end else if (res_in.valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = out_word;
            end
        end else if (m_tready) begin
            m_data_next     = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_price_reg <= '0;
            perr_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            held_price_reg <= held_price_next;
            perr_reg       <= perr_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/fix_tag_value_parser_top.sv
// FIX tag=value parser: takes one message byte per clock cycle, s_tlast on the final
// byte, and gives one packed result word per message once the final byte has passed
// the parser register, range check and partial products, product sum and result
// register. The input is held off only while a result waits in the output
// register and a second one fills the skid register behind it.
// Depends on fix_tvp_pkg, fix_tvp_parse, fix_tvp_price and fix_tvp_out.
module fix_tag_value_parser_top #(
    parameter int TYPE_BYTES   = fix_tvp_pkg::DEF_TYPE_BYTES,
    parameter int SYMBOL_BYTES = fix_tvp_pkg::DEF_SYMBOL_BYTES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: byte_in[7:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fix_tvp_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // m_tdata: message_type[15:0], symbol_text[79:16], price_scaled[143:80],
    // quantity[207:144], side[209:208], format_error[210], zeros above
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fix_tvp_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_we,
    input  logic [fix_tvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fix_tvp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fix_tvp_pkg::*;

    logic [BYTE_W-1:0] field_sep_reg;
    logic [DEC_W-1:0]  price_dec_reg;
    logic              adv;
    logic              in_accept;
    price_ev_t         ev;
    result_t           res_parse;
    price_sum_t        sum;
    result_t           res_price;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_sep_reg <= SEP_RESET;
            price_dec_reg <= DEC_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FIELD_SEP: field_sep_reg <= cfg_wdata;
                CFG_PRICE_DEC: price_dec_reg <= cfg_wdata[DEC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready  = adv;
    assign in_accept = s_tvalid && s_tready;

    fix_tvp_parse #(
        .TYPE_BYTES   (TYPE_BYTES),
        .SYMBOL_BYTES (SYMBOL_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .field_sep (field_sep_reg),
        .price_dec (price_dec_reg),
        .adv       (adv),
        .ev_out    (ev),
        .res_out   (res_parse)
    );

    fix_tvp_price u_price (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ev_in   (ev),
        .res_in  (res_parse),
        .sum_out (sum),
        .res_out (res_price)
    );

    fix_tvp_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sum_in   (sum),
        .res_in   (res_price),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .adv      (adv)
    );

    // The input is only held off while a finished result is waiting.
    a_stall_only_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // A result never carries the unused side code.
    a_side_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[209:208] == SIDE_NONE || m_tdata[209:208] == SIDE_BUY
                      || m_tdata[209:208] == SIDE_SELL))
        else $error("result carries an invalid side code");

    // No result appears in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

>>> tb/fix_tvp_checker.sv
// Watching checker for the FIX tag=value parser: follows the byte stream, the result
// stream and the register port, predicts every message summary and compares it.
// Depends on fix_tvp_pkg only; hands its failure count to the testbench top.
module fix_tvp_checker
    import fix_tvp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bit positions of the fields inside a result word.
    localparam int OFS_SYMBOL = TYPE_W;
    localparam int OFS_PRICE  = OFS_SYMBOL + SYMBOL_W;
    localparam int OFS_QTY    = OFS_PRICE + PRICE_W;
    localparam int OFS_SIDE   = OFS_QTY + QTY_W;
    localparam int OFS_ERR    = OFS_SIDE + SIDE_W;

    localparam int MAX_PRINTED = 100;

    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_ONE   = "1";
    localparam logic [7:0] CH_THREE = "3";
    localparam logic [7:0] CH_FOUR  = "4";
    localparam logic [7:0] CH_FIVE  = "5";
    localparam logic [7:0] CH_EIGHT = "8";
    localparam logic [7:0] CH_NINE  = "9";

    // Recognised tags, plus the one-digit prefixes seen while a tag is being read.
    typedef enum logic [3:0] {
        TK_NONE,
        TK_MSGTYPE,
        TK_SYMBOL,
        TK_PRICE,
        TK_QTY,
        TK_SIDE,
        TK_PRE3,
        TK_PRE4,
        TK_PRE5
    } tag_t;

    typedef struct {
        logic [TYPE_W-1:0]   msg_type;
        logic [SYMBOL_W-1:0] symbol;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    qty;
        logic [SIDE_W-1:0]   side;
        logic                err;
    } summary_t;

    summary_t summaries_due[$];
    int       words_seen;

    // Register copies.
    logic [7:0]       sep_byte;
    logic [DEC_W-1:0] dec_reg;

    // Field state.
    logic        in_value;
    tag_t        tag;
    logic [1:0]  tag_len;
    logic [63:0] acc;
    logic [3:0]  frac_cnt;
    logic        f_neg, f_dot, f_digit, f_bad;
    logic [3:0]  vcount;
    logic        acc_over;

    // Message state.
    logic [TYPE_W-1:0]   held_type;
    logic [SYMBOL_W-1:0] held_sym;
    logic [PRICE_W-1:0]  held_price;
    logic [QTY_W-1:0]    held_qty;
    logic [SIDE_W-1:0]   held_side;
    logic                err_seen;

    function automatic logic [63:0] ten_to(int unsigned n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++) v = v * 64'd10;
        return v;
    endfunction

    // Settings above the largest scale behave as the largest scale.
    function int unsigned kept_decimals();
        return (dec_reg > MAX_DECIMALS) ? MAX_DECIMALS : dec_reg;
    endfunction

    function void clear_field();
        in_value = 1'b0;
        tag      = TK_NONE;
        tag_len  = 2'd0;
        acc      = 64'd0;
        frac_cnt = 4'd0;
        f_neg    = 1'b0;
        f_dot    = 1'b0;
        f_digit  = 1'b0;
        f_bad    = 1'b0;
        vcount   = 4'd0;
        acc_over = 1'b0;
    endfunction

    function void clear_message();
        clear_field();
        held_type  = '0;
        held_sym   = '0;
        held_price = '0;
        held_qty   = '0;
        held_side  = SIDE_NONE;
        err_seen   = 1'b0;
    endfunction

    // Accumulate one decimal digit; once the limit would be passed the value freezes.
    function void add_digit(logic [7:0] c, logic [63:0] limit);
        logic [63:0] d;
        d = {56'd0, c - CH_ZERO};
        if (!acc_over) begin
            if (acc > (limit - d) / 64'd10) begin
                acc_over = 1'b1;
            end else begin
                acc = acc * 64'd10 + d;
            end
        end
    endfunction

    // Tags are at most two bytes long; anything longer matches nothing.
    function void take_tag_byte(logic [7:0] c);
        if (tag_len >= 2'd2) begin
            tag_len = 2'd3;
            tag     = TK_NONE;
        end else begin
            if (tag_len == 2'd0) begin
                if (c == CH_THREE) tag = TK_PRE3;
                else if (c == CH_FIVE) tag = TK_PRE5;
                else if (c == CH_FOUR) tag = TK_PRE4;
                else tag = TK_NONE;
            end else begin
                case (tag)
                    TK_PRE3: begin
                        if (c == CH_FIVE) tag = TK_MSGTYPE;
                        else if (c == CH_EIGHT) tag = TK_QTY;
                        else tag = TK_NONE;
                    end
                    TK_PRE5: begin
                        if (c == CH_FIVE) tag = TK_SYMBOL;
                        else if (c == CH_FOUR) tag = TK_SIDE;
                        else tag = TK_NONE;
                    end
                    TK_PRE4: begin
                        if (c == CH_FOUR) tag = TK_PRICE;
                        else tag = TK_NONE;
                    end
                    default: tag = TK_NONE;
                endcase
            end
            tag_len = tag_len + 2'd1;
        end
    endfunction

    // The first '=' opens the value; text tags start again from empty.
    function void open_value();
        if (tag_len != 2'd2) tag = TK_NONE;
        in_value = 1'b1;
        if (tag == TK_MSGTYPE) held_type = '0;
        else if (tag == TK_SYMBOL) held_sym = '0;
    endfunction

    function void take_value_byte(logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (tag)
            TK_MSGTYPE: begin
                if (vcount < DEF_TYPE_BYTES)
                    held_type[8*(DEF_TYPE_BYTES-1-vcount) +: 8] = c;
            end
            TK_SYMBOL: begin
                if (vcount < DEF_SYMBOL_BYTES)
                    held_sym[8*(DEF_SYMBOL_BYTES-1-vcount) +: 8] = c;
            end
            TK_SIDE: begin
                if (vcount == 4'd0 && c == CH_ONE) f_digit = 1'b1;
            end
            TK_PRICE: begin
                if (is_digit) begin
                    f_digit = 1'b1;
                    if (!f_dot) begin
                        add_digit(c, MAG_LIMIT);
                    end else if (frac_cnt < kept_decimals()) begin
                        add_digit(c, MAG_LIMIT);
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else if (c == CH_DOT && !f_dot) begin
                    f_dot = 1'b1;
                end else if ((c == CH_MINUS || c == CH_PLUS) && vcount == 4'd0) begin
                    if (c == CH_MINUS) f_neg = 1'b1;
                end else begin
                    f_bad = 1'b1;
                end
            end
            TK_QTY: begin
                if (is_digit) begin
                    f_digit = 1'b1;
                    add_digit(c, '1);
                end else if (!(c == CH_PLUS && vcount == 4'd0)) begin
                    f_bad = 1'b1;
                end
            end
            default: ;
        endcase
        if (vcount < 4'd15) vcount = vcount + 4'd1;
    endfunction

    // Scale the price up to the kept decimals, then saturate or apply the sign; a bad or empty price gives zero.
    function void close_price();
        int unsigned k;
        logic [63:0] mag;
        logic [63:0] scale;
        if (kept_decimals() > frac_cnt) k = kept_decimals() - frac_cnt;
        else k = 0;
        mag = acc;
        if (f_bad || !f_digit) begin
            held_price = '0;
            err_seen   = 1'b1;
            return;
        end
        if (!acc_over) begin
            scale = ten_to(k);
            if (mag > MAG_LIMIT / scale) acc_over = 1'b1;
            else mag = mag * scale;
        end
        if (!acc_over && !f_neg && mag == MAG_LIMIT) acc_over = 1'b1;
        if (acc_over) begin
            held_price = f_neg ? MAG_LIMIT : MAG_LIMIT - 64'd1;
            err_seen   = 1'b1;
        end else begin
            held_price = f_neg ? 64'd0 - mag : mag;
        end
    endfunction

    function void close_field();
        if (in_value) begin
            case (tag)
                TK_PRICE: close_price();
                TK_QTY: begin
                    if (f_bad || !f_digit) begin
                        held_qty = '0;
                        err_seen = 1'b1;
                    end else if (acc_over) begin
                        held_qty = '1;
                        err_seen = 1'b1;
                    end else begin
                        held_qty = acc;
                    end
                end
                TK_SIDE: held_side = (vcount == 4'd1 && f_digit) ? SIDE_BUY : SIDE_SELL;
                default: ;
            endcase
        end
        clear_field();
    endfunction

    // One accepted message byte; the final byte closes the message and yields a summary.
    function void parse_byte(logic [7:0] c, logic last);
        summary_t s;
        if (c == sep_byte) close_field();
        else if (in_value) take_value_byte(c);
        else if (c == CH_EQ) open_value();
        else take_tag_byte(c);
        if (last) begin
            close_field();
            s.msg_type = held_type;
            s.symbol   = held_sym;
            s.price    = held_price;
            s.qty      = held_qty;
            s.side     = held_side;
            s.err      = err_seen;
            summaries_due.push_back(s);
            clear_message();
        end
    endfunction

    task flag_error(input string what);
        if (mismatches < MAX_PRINTED) $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task compare_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %h, expected %h",
                                 words_seen, name, got, want));
    endtask

    // Compare one result word with the oldest outstanding summary.
    task check_word(input logic [M_TDATA_W-1:0] w);
        summary_t want;
        if (summaries_due.size() == 0) begin
            flag_error($sformatf("result word with no message outstanding: %h", w));
            return;
        end
        want = summaries_due.pop_front();
        compare_field("message_type", 64'(w[0 +: TYPE_W]), 64'(want.msg_type));
        compare_field("symbol_text", w[OFS_SYMBOL +: SYMBOL_W], want.symbol);
        compare_field("price_scaled", w[OFS_PRICE +: PRICE_W], want.price);
        compare_field("quantity", w[OFS_QTY +: QTY_W], want.qty);
        compare_field("side", 64'(w[OFS_SIDE +: SIDE_W]), 64'(want.side));
        compare_field("format_error", 64'(w[OFS_ERR]), 64'(want.err));
    endtask

    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge aclk) begin
        if (!aresetn) begin
            sep_byte   = SEP_RESET;
            dec_reg    = DEC_RESET;
            words_seen = 0;
            mismatches = 0;
            summaries_due.delete();
            clear_message();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FIELD_SEP: sep_byte = cfg_wdata[7:0];
                    CFG_PRICE_DEC: dec_reg = cfg_wdata[DEC_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                check_word(m_tdata);
                words_seen++;
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
        end
        outstanding = summaries_due.size();
    end

endmodule

>>> tb/tb_fix_tag_value_parser_top.sv
// Testbench top for the FIX tag=value parser: drives message bytes, register writes
// and result back-pressure, and gives the verdict from the checker's failure count.
// Depends on fix_tvp_pkg, fix_tag_value_parser_top and fix_tvp_checker.
module tb_fix_tag_value_parser_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fix_tvp_pkg::*;

    localparam int CLOCK_LIMIT     = 300000;
    localparam int TARGET_BYTES    = 750;
    localparam int TARGET_MESSAGES = 60;
    localparam int PHASE_MESSAGES  = 9;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_SETTINGS      = 7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatches;
    int outstanding;

    // Message under construction, and progress counters.
    logic [7:0] msg_q[$];
    logic [7:0] cur_sep;
    logic       calm = 1'b0;
    int         bytes_sent;
    int         msgs_sent;
    int         cycle_count;

    fix_tag_value_parser_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fix_tvp_checker summary_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side stalls at random, with ready low about 30 percent of the time, except in the calm stretch.
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CLOCK_LIMIT) begin
            $display("fix_tag_value_parser_top: mismatch");
            $finish;
        end
    end

    // Register settings visited by the random phases.
    function automatic logic [7:0] phase_sep(int p);
        case (p)
            0: return 8'd124;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'd0;
            4: return "=";
            5: return ",";
            default: return 8'd124;
        endcase
    endfunction

    function automatic logic [3:0] phase_dec(int p);
        case (p)
            0: return 4'd4;
            1: return 4'd8;
            2: return 4'd0;
            3: return 4'd2;
            4: return 4'd5;
            5: return 4'd8;
            default: return 4'd3;
        endcase
    endfunction

    function void put_byte(logic [7:0] b);
        msg_q.push_back(b);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    endfunction

    function void put_digits(int n);
        repeat (n) put_byte(8'($urandom_range(48, 57)));
    endfunction

    // One field with random content; mostly the tags the parser keeps.
    function void build_field();
        string bad_chars;
        int    kind;
        int    r;
        bad_chars = "x -.e+,";
        kind = $urandom_range(0, 99);
        if (kind < 14) begin
            put_text("35=");
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(65, 90)));
        end else if (kind < 28) begin
            put_text("55=");
            repeat ($urandom_range(0, 11)) begin
                if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(65, 90)));
                else put_byte(8'($urandom_range(0, 255)));
            end
        end else if (kind < 48) begin
            put_text("44=");
            r = $urandom_range(0, 99);
            if (r < 20) put_byte("-");
            else if (r < 25) put_byte("+");
            r = $urandom_range(0, 99);
            if (r < 8) put_digits(0);
            else if (r < 93) put_digits($urandom_range(1, 6));
            else put_digits($urandom_range(14, 21));
            if ($urandom_range(0, 99) < 60) begin
                put_byte(".");
                put_digits($urandom_range(0, 10));
            end
            if ($urandom_range(0, 99) < 10)
                put_byte(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
        end else if (kind < 63) begin
            put_text("38=");
            if ($urandom_range(0, 99) < 10) put_byte("+");
            r = $urandom_range(0, 99);
            if (r < 6) put_digits(0);
            else if (r < 92) put_digits($urandom_range(1, 9));
            else put_digits($urandom_range(18, 21));
            if ($urandom_range(0, 99) < 8)
                put_byte(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
        end else if (kind < 76) begin
            put_text("54=");
            case ($urandom_range(0, 5))
                0, 1: put_text("1");
                2: put_text("2");
                3: put_text("11");
                4: ;
                default: begin
                    put_text("1");
                    put_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end else if (kind < 85) begin
            // A numeric tag of zero to four digits, sometimes one of the kept tags by chance.
            put_digits($urandom_range(0, 4));
            put_byte("=");
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(65, 90)));
        end else if (kind < 91) begin
            // Field of random bytes from '0' to 'Z', so an equals sign may appear in it.
            repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(48, 90)));
        end else if (kind < 95) begin
            // Empty field.
        end else begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // A message of a few fields; now and then pure noise.
    function void build_message();
        int n;
        if ($urandom_range(0, 99) < 5) begin
            repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 99) < 40) begin
            put_text("8=FIX.4.4");
            put_byte(cur_sep);
        end
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            build_field();
            if (i < n - 1 || $urandom_range(0, 1) == 1) put_byte(cur_sep);
        end
        if (msg_q.size() == 0) put_byte(cur_sep);
    endfunction

    // Offer one byte, with random idle cycles first, and wait for it to be taken.
    // Entered and left at a falling edge; the valid stays high for the next byte.
    task send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task send_message();
        for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
        bytes_sent += msg_q.size();
        msgs_sent++;
        msg_q.delete();
    endtask

    task send_text(input string s);
        put_text(s);
        send_message();
    endtask

    // Stop sending and let every outstanding result come out, then settle.
    task wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task apply_config(input logic [7:0] sep, input logic [3:0] dec);
        write_reg(CFG_FIELD_SEP, sep);
        write_reg(CFG_PRICE_DEC, {4'd0, dec});
        cur_sep = sep;
    endtask

    initial begin
        int phase;
        int phase_msgs;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FIELD_SEP;
        cfg_wdata = '0;
        cur_sep   = SEP_RESET;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed messages at the default pipe separator and four decimals.
        apply_config(8'd124, 4'd4);
        send_text("8=FIX.4.4|35=D|55=IBM|54=1|44=123.45|38=100|");
        send_text("35=ABC|55=ABCDEFGHIJK|54=2|44=-0.123456|38=+7");
        send_text("44=1.2.3|38=12a|54=11|55=X=Y=Z|35=|");
        send_text("44=-|38=|54=|44=.|38=-5");
        send_text("38=18446744073709551615|44=-922337203685477.5808|");
        send_text("38=18446744073709551616|44=922337203685477.5808|");
        send_text("|");
        send_text("44=5|44=6|555=Z|3=1|=9|abc|35=0|54=1|54=3");
        send_text("44=-99999999999999999999|38=99999999999999999999999");
        send_text("44=+.5|55=|35=AB");

        // Price limits with no fraction digits kept.
        wait_for_results();
        apply_config(8'd124, 4'd0);
        send_text("44=9223372036854775807|38=0");
        send_text("44=-9223372036854775808.99|54=1");
        send_text("44=9223372036854775808");
        send_text("44=1.999|38=00042|");

        // Random messages over a round of register settings.
        phase      = 0;
        phase_msgs = PHASE_MESSAGES;
        while (bytes_sent < TARGET_BYTES || msgs_sent < TARGET_MESSAGES) begin
            if (phase_msgs == PHASE_MESSAGES) begin
                wait_for_results();
                apply_config(phase_sep(phase), phase_dec(phase));
                phase      = (phase + 1) % N_SETTINGS;
                phase_msgs = 0;
            end
            calm <= (msgs_sent >= 24 && msgs_sent < 36);
            build_message();
            send_message();
            phase_msgs++;
        end

        wait_for_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("fix_tag_value_parser_top: match");
        end else begin
            $display("fix_tag_value_parser_top: mismatch");
        end
        $finish;
    end

endmodule
